FILE: sv/pcf_pkg.sv
// Package for the PGN comment filter: character codes, result tokens,
// shared types and the whitespace test. No dependencies.
package pcf_pkg;

   localparam int NestMaxDefault = 15;
   localparam int SuffixLen      = 7;
   localparam int CountW         = 3;

   typedef logic [7:0] char_type;
   typedef logic [SuffixLen-1:0][7:0] suffix_type;
   typedef logic [CountW-1:0] count_type;

   localparam char_type ChBraceOpen  = 8'h7b;
   localparam char_type ChBraceClose = 8'h7d;
   localparam char_type ChParenOpen  = 8'h28;
   localparam char_type ChParenClose = 8'h29;
   localparam char_type ChTagOpen    = 8'h5b;
   localparam char_type ChTagClose   = 8'h5d;
   localparam char_type ChSemicolon  = 8'h3b;
   localparam char_type ChSpace      = 8'h20;
   localparam char_type ChTab        = 8'h09;
   localparam char_type ChCr         = 8'h0d;

   localparam logic [7:0]  TokUnknown = "*";
   localparam logic [23:0] TokWhite   = "1-0";
   localparam logic [23:0] TokBlack   = "0-1";
   localparam logic [55:0] TokDraw    = "1/2-1/2";

   typedef struct packed {
      logic in_tag;
      logic in_line_comment;
   } flags_type;

   typedef struct packed {
      char_type char_out;
      logic     char_kept;
      logic     line_done;
      logic     game_over;
   } result_type;

   function automatic logic is_blank(input char_type c);
      return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
   endfunction

endpackage

FILE: sv/pcf_step.sv
// Per-item logic of the PGN comment filter: nesting and flag update,
// line suffix tracking and the result token test. Uses pcf_pkg.
module pcf_step #(
   parameter int NEST_MAX = pcf_pkg::NestMaxDefault,
   parameter int DepthW   = $clog2(NEST_MAX + 1)
) (
   input  pcf_pkg::char_type   char_in,
   input  logic                line_first,
   input  logic                line_last,
   input  logic                clear_nesting,
   input  logic [DepthW-1:0]   brace_cur,
   input  logic [DepthW-1:0]   paren_cur,
   input  pcf_pkg::flags_type  flags_cur,
   input  pcf_pkg::suffix_type suffix_cur,
   input  pcf_pkg::count_type  count_cur,
   output logic [DepthW-1:0]   brace_nxt,
   output logic [DepthW-1:0]   paren_nxt,
   output pcf_pkg::flags_type  flags_nxt,
   output pcf_pkg::suffix_type suffix_nxt,
   output pcf_pkg::count_type  count_nxt,
   output pcf_pkg::result_type result
);
   import pcf_pkg::*;

   localparam logic [DepthW-1:0] DepthMax = DepthW'(NEST_MAX);

   logic [DepthW-1:0] brace;
   logic [DepthW-1:0] paren;
   flags_type         flags;
   count_type         count;
   logic              kept;
   logic              over;
   logic              nest_clear;

   always_comb begin
      brace      = clear_nesting ? '0 : brace_cur;
      paren      = clear_nesting ? '0 : paren_cur;
      flags      = clear_nesting ? '0 : flags_cur;
      count      = line_first ? '0 : count_cur;
      nest_clear = (brace == '0) && (paren == '0) && !flags.in_tag;
      kept       = 1'b0;
      suffix_nxt = suffix_cur;

      brace_nxt = brace;
      paren_nxt = paren;
      flags_nxt = flags;
      count_nxt = count;

      priority if (char_in == ChBraceOpen) begin
         if (!flags.in_tag && brace < DepthMax) brace_nxt = brace + 1'b1;
      end else if (char_in == ChParenOpen) begin
         if (!flags.in_tag && brace == '0 && paren < DepthMax) paren_nxt = paren + 1'b1;
      end else if (char_in == ChBraceClose) begin
         if (brace != '0) brace_nxt = brace - 1'b1;
      end else if (char_in == ChParenClose) begin
         if (paren != '0 && brace == '0) paren_nxt = paren - 1'b1;
      end else if (char_in == ChTagOpen && line_first) begin
         if (nest_clear) flags_nxt.in_tag = 1'b1;
      end else if (char_in == ChTagClose && line_last) begin
         flags_nxt.in_tag = 1'b0;
      end else if (char_in == ChSemicolon) begin
         if (nest_clear) flags_nxt.in_line_comment = 1'b1;
      end else if (nest_clear && !flags.in_line_comment) begin
         kept = 1'b1;
         if (!is_blank(char_in)) begin
            suffix_nxt = {suffix_cur[SuffixLen-2:0], char_in};
            if (count != count_type'(SuffixLen)) count_nxt = count + 1'b1;
         end
      end

      // The newest byte sits at index zero, so each token is a low slice.
      over = line_last && (
             (count_nxt >= count_type'(1) && suffix_nxt[0] == TokUnknown) ||
             (count_nxt >= count_type'(3) && suffix_nxt[2:0] == TokWhite) ||
             (count_nxt >= count_type'(3) && suffix_nxt[2:0] == TokBlack) ||
             (count_nxt == count_type'(SuffixLen) && suffix_nxt == TokDraw));

      if (line_last) begin
         flags_nxt.in_line_comment = 1'b0;
         count_nxt                 = '0;
      end

      result.char_out  = kept ? char_in : '0;
      result.char_kept = kept;
      result.line_done = line_last;
      result.game_over = over;
   end

endmodule

FILE: sv/pgn_comment_filter.sv
// Top level of the PGN comment filter: input register, state registers and
// result register around pcf_step. Uses pcf_pkg and pcf_step.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    char_in, line_first, line_last,
//                                              clear_nesting
//   rsp      out        rsp_valid/rsp_ready    char_out, char_kept, line_done,
//                                              game_over
//
// Each item is held in the input register and then moves into the result
// register.
// One item is accepted per cycle while rsp is not stalled; the filter state updates as an item moves
// into the result register. A stalled result holds both registers, and the
// input side keeps accepting while either register is free.
// Reset is synchronous and empties both registers and clears the nesting depths, flags and suffix count.
module pgn_comment_filter #(
   parameter int NEST_MAX = pcf_pkg::NestMaxDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  pcf_pkg::char_type  req_char_in,
   input  logic               req_line_first,
   input  logic               req_line_last,
   input  logic               req_clear_nesting,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output pcf_pkg::char_type  rsp_char_out,
   output logic               rsp_char_kept,
   output logic               rsp_line_done,
   output logic               rsp_game_over
);
   import pcf_pkg::*;

   localparam int DepthW = $clog2(NEST_MAX + 1);

   logic              in_vld_ff,   in_vld_in;
   char_type          in_char_ff;
   logic              in_first_ff;
   logic              in_last_ff;
   logic              in_clear_ff;
   logic              rsp_vld_ff,  rsp_vld_in;
   result_type        result_ff,   result_in;
   logic [DepthW-1:0] brace_ff,    brace_in;
   logic [DepthW-1:0] paren_ff,    paren_in;
   flags_type         flags_ff,    flags_in;
   suffix_type        suffix_ff,   suffix_in;
   count_type         count_ff,    count_in;
   logic              advance;
   logic              accept;

   assign advance   = in_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;
   assign accept    = req_valid && req_ready;

   always_comb begin
      in_vld_in  = accept ? 1'b1 : (advance ? 1'b0 : in_vld_ff);
      rsp_vld_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_vld_ff);
   end

   pcf_step #(
      .NEST_MAX (NEST_MAX),
      .DepthW   (DepthW)
   ) u_step (
      .char_in       (in_char_ff),
      .line_first    (in_first_ff),
      .line_last     (in_last_ff),
      .clear_nesting (in_clear_ff),
      .brace_cur     (brace_ff),
      .paren_cur     (paren_ff),
      .flags_cur     (flags_ff),
      .suffix_cur    (suffix_ff),
      .count_cur     (count_ff),
      .brace_nxt     (brace_in),
      .paren_nxt     (paren_in),
      .flags_nxt     (flags_in),
      .suffix_nxt    (suffix_in),
      .count_nxt     (count_in),
      .result        (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         brace_ff   <= '0;
         paren_ff   <= '0;
         flags_ff   <= '0;
         count_ff   <= '0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (advance) begin
            brace_ff <= brace_in;
            paren_ff <= paren_in;
            flags_ff <= flags_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_char_ff  <= req_char_in;
         in_first_ff <= req_line_first;
         in_last_ff  <= req_line_last;
         in_clear_ff <= req_clear_nesting;
      end
      if (advance) begin
         suffix_ff <= suffix_in;
         result_ff <= result_in;
      end
   end

   assign rsp_valid     = rsp_vld_ff;
   assign rsp_char_out  = result_ff.char_out;
   assign rsp_char_kept = result_ff.char_kept;
   assign rsp_line_done = result_ff.line_done;
   assign rsp_game_over = result_ff.game_over;

endmodule

FILE: sv/pcf_checker.sv
// Port-level checks for the PGN comment filter, attached by bind.
// Uses pcf_pkg and the ports of pgn_comment_filter.
module pcf_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input pcf_pkg::char_type rsp_char_out,
   input logic              rsp_char_kept,
   input logic              rsp_line_done,
   input logic              rsp_game_over
);
   import pcf_pkg::*;

   // A stalled result keeps its whole payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_char_out) &&
      $stable(rsp_char_kept) && $stable(rsp_line_done) && $stable(rsp_game_over))
      else $error("stalled result item changed");

   // A dropped byte always shows as zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_char_kept |-> rsp_char_out == '0)
      else $error("dropped item carries a nonzero byte");

   // The result token is only reported at a line end.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_game_over |-> rsp_line_done)
      else $error("game over reported inside a line");

   // Braces, parentheses and semicolons never pass through.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_char_kept |->
      rsp_char_out != ChBraceOpen && rsp_char_out != ChBraceClose &&
      rsp_char_out != ChParenOpen && rsp_char_out != ChParenClose &&
      rsp_char_out != ChSemicolon)
      else $error("brace, parenthesis or semicolon was kept");

endmodule

bind pgn_comment_filter pcf_checker u_pcf_checker (.*);

FILE: verif/tb_pgn_comment_filter.sv
// Self-checking testbench for pgn_comment_filter: directed and random PGN-like lines go in,
// and every filtered byte is checked against a line tracker in the scoreboard.
// Depends on pcf_pkg and the pgn_comment_filter RTL.
module tb_pgn_comment_filter;
   import pcf_pkg::*;

   class pgn_filter_scoreboard;
      result_type expected_outputs[$];
      int         nest_max;
      int         brace_depth;
      int         paren_depth;
      bit         in_tag;
      bit         in_line_comment;
      logic [55:0] line_tail;
      int         tail_len;
      int         errors;
      int         checked;
      int         token_lines;
      int         saturations;

      function new(int nest_max_i);
         nest_max = nest_max_i;
      endfunction

      function int deepen(int d);
         if (d >= nest_max) begin
            saturations++;
            return nest_max;
         end
         return d + 1;
      endfunction

      function bit ends_in_result();
         return (tail_len >= 1 && line_tail[7:0] == TokUnknown) ||
                (tail_len >= 3 && line_tail[23:0] == TokWhite) ||
                (tail_len >= 3 && line_tail[23:0] == TokBlack) ||
                (tail_len >= 7 && line_tail == TokDraw);
      endfunction

      // Predicts the output for one accepted byte and queues it.
      function void filter_byte(char_type c, logic is_first, logic is_last, logic clr);
         result_type exp;
         bit outside;
         exp = '0;
         if (clr) begin
            brace_depth = 0;
            paren_depth = 0;
            in_tag = 0;
            in_line_comment = 0;
         end
         if (is_first) begin
            line_tail = '0;
            tail_len = 0;
         end
         outside = !in_tag && brace_depth == 0 && paren_depth == 0;
         if (c == ChBraceOpen) begin
            if (!in_tag) brace_depth = deepen(brace_depth);
         end else if (c == ChParenOpen) begin
            if (!in_tag && brace_depth == 0) paren_depth = deepen(paren_depth);
         end else if (c == ChBraceClose) begin
            if (brace_depth > 0) brace_depth--;
         end else if (c == ChParenClose) begin
            if (paren_depth > 0 && brace_depth == 0) paren_depth--;
         end else if (c == ChTagOpen && is_first) begin
            if (outside) in_tag = 1;
         end else if (c == ChTagClose && is_last) begin
            in_tag = 0;
         end else if (c == ChSemicolon) begin
            if (outside) in_line_comment = 1;
         end else if (outside && !in_line_comment) begin
            exp.char_out = c;
            exp.char_kept = 1'b1;
            if (!(c == ChSpace || (c >= ChTab && c <= ChCr))) begin
               line_tail = {line_tail[47:0], c};
               if (tail_len < SuffixLen) tail_len++;
            end
         end
         if (is_last) begin
            exp.line_done = 1'b1;
            exp.game_over = ends_in_result();
            if (exp.game_over) token_lines++;
            in_line_comment = 0;
            line_tail = '0;
            tail_len = 0;
         end
         expected_outputs = {expected_outputs, exp};
      endfunction

      function void check_output(result_type got);
         result_type exp;
         checked++;
         if (expected_outputs.size() == 0) begin
            errors++;
            $display("%0t: unexpected output char %h kept %b done %b over %b", $time,
                     got.char_out, got.char_kept, got.line_done, got.game_over);
            return;
         end
         exp = expected_outputs.pop_front();
         if (got !== exp) begin
            errors++;
            $display("%0t: expected char %h kept %b done %b over %b", $time,
                     exp.char_out, exp.char_kept, exp.line_done, exp.game_over);
            $display("%0t: actual   char %h kept %b done %b over %b", $time,
                     got.char_out, got.char_kept, got.line_done, got.game_over);
         end
      endfunction

      function int pending();
         return expected_outputs.size();
      endfunction
   endclass

   localparam int IdleLimit = 1000;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_ready;
   char_type req_char_in = '0;
   logic     req_line_first = 1'b0;
   logic     req_line_last = 1'b0;
   logic     req_clear_nesting = 1'b0;
   logic     rsp_valid;
   logic     rsp_ready = 1'b0;
   char_type rsp_char_out;
   logic     rsp_char_kept;
   logic     rsp_line_done;
   logic     rsp_game_over;

   pgn_filter_scoreboard sb = new(NestMaxDefault);
   char_type line_bytes[$];
   bit       quiet = 0;
   int       gap_pct = 15;
   int       bytes_sent = 0;
   int       lines_sent = 0;
   int       stall_left = 0;
   int       idle_cycles = 0;
   string    move_chars = "abcdefghNBRQKO12345678x+#=-.";

   pgn_comment_filter DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_char_in       (req_char_in),
      .req_line_first    (req_line_first),
      .req_line_last     (req_line_last),
      .req_clear_nesting (req_clear_nesting),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_char_out      (rsp_char_out),
      .rsp_char_kept     (rsp_char_kept),
      .rsp_line_done     (rsp_line_done),
      .rsp_game_over     (rsp_game_over)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void add_byte(char_type c);
      line_bytes = {line_bytes, c};
   endfunction

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) add_byte(char_type'(s[i]));
   endfunction

   function automatic void add_move();
      repeat ($urandom_range(1, 4))
         add_byte(char_type'(move_chars[$urandom_range(0, move_chars.len() - 1)]));
   endfunction

   function automatic void add_result();
      case ($urandom_range(0, 7))
         0: add_text("1-0");
         1: add_text("0-1");
         2: add_text("1/2-1/2");
         3: add_text("*");
         4: add_text("1-1");
         5: add_text("2-1/2");
         6: add_text("1/2-1");
         default: add_text("0-0");
      endcase
   endfunction

   function automatic void build_game_line();
      char_type opener, closer;
      int k;
      line_bytes.delete();
      if ($urandom_range(0, 7) == 0) begin
         add_text("[Site \"");
         add_move();
         if ($urandom_range(0, 2) == 0) add_byte(char_type'($urandom_range(0, 255)));
         add_text("\"]");
         return;
      end
      repeat ($urandom_range(1, 6)) begin
         case ($urandom_range(0, 11))
            0, 1, 2: add_move();
            3: add_byte($urandom_range(0, 1) ? ChSpace : char_type'($urandom_range(9, 13)));
            4: begin
               add_text("{");
               add_move();
               if ($urandom_range(0, 2) == 0) add_text("{(;)}");
               add_text("}");
            end
            5: begin
               add_text("(");
               add_move();
               add_text(" ");
               add_move();
               add_text(")");
            end
            6: begin
               add_text(";");
               add_move();
            end
            7: add_byte(char_type'($urandom_range(0, 255)));
            8: begin
               opener = $urandom_range(0, 1) ? ChBraceOpen : ChParenOpen;
               closer = (opener == ChBraceOpen) ? ChBraceClose : ChParenClose;
               k = $urandom_range(13, 18);
               repeat (k) add_byte(opener);
               repeat ($urandom_range(k - 3, k + 1)) add_byte(closer);
            end
            9: case ($urandom_range(0, 3))
               0: add_byte(ChTagOpen);
               1: add_byte(ChTagClose);
               2: add_byte(ChBraceClose);
               default: add_byte(ChParenClose);
            endcase
            10: add_result();
            default: add_byte($urandom_range(0, 1) ? ChBraceOpen : ChParenOpen);
         endcase
      end
      if ($urandom_range(0, 2) == 0) begin
         add_result();
         case ($urandom_range(0, 3))
            0: add_text("  ");
            1: add_text(" {end}");
            2: add_text(" ; done");
            default: ;
         endcase
      end
   endfunction

   task automatic send_byte(char_type c, logic is_first, logic is_last, logic clr);
      if (!quiet && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_char_in <= c;
      req_line_first <= is_first;
      req_line_last <= is_last;
      req_clear_nesting <= clr;
      do @(posedge clock); while (!req_ready);
      sb.filter_byte(c, is_first, is_last, clr);
      bytes_sent++;
   endtask

   task automatic send_line(bit noisy);
      bit mark_first, mark_last, clear_at_start;
      int n;
      mark_first = 1;
      mark_last = 1;
      clear_at_start = 0;
      n = line_bytes.size();
      if (noisy) begin
         mark_first = ($urandom_range(0, 9) != 0);
         mark_last = ($urandom_range(0, 9) != 0);
         clear_at_start = ($urandom_range(0, 7) == 0);
         gap_pct = ($urandom_range(0, 3) == 0) ? 0 : 15;
      end
      for (int i = 0; i < n; i++)
         send_byte(line_bytes[i], mark_first && i == 0, mark_last && i == n - 1,
                   noisy && ((i == 0 && clear_at_start) || $urandom_range(0, 59) == 0));
      lines_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   always @(posedge clock) begin : sink
      result_type got;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_char_out, rsp_char_kept, rsp_line_done, rsp_game_over};
            sb.check_output(got);
         end
         if (quiet) begin
            rsp_ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if ($urandom_range(0, 6) == 0) begin
            stall_left = $urandom_range(0, 2);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IdleLimit) begin
            $display("%0t: no progress for %0d cycles", $time, IdleLimit);
            $display("tb_pgn_comment_filter NOT OK");
            $finish;
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      add_text("[T]");
      send_line(0);
      line_bytes.delete();
      add_text("1/2-1/2");
      send_line(0);
      line_bytes.delete();
      add_text("(a)0-1");
      send_line(0);
      line_bytes.delete();
      add_text("{}1-0;x");
      send_line(0);
      line_bytes.delete();
      add_text("*");
      send_line(0);
      send_byte(8'hff, 1'b1, 1'b0, 1'b1);
      send_byte(8'h00, 1'b0, 1'b1, 1'b0);
      drain();

      while (bytes_sent < 950) begin
         build_game_line();
         send_line(1);
         if (lines_sent == 60) drain();
         if (bytes_sent >= 800) quiet = 1;
      end
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("Filtered %0d bytes in %0d lines; %0d line ends carried a result token.",
               bytes_sent, lines_sent, sb.token_lines);
      $display("Nesting reached its ceiling %0d times; %0d outputs were checked.",
               sb.saturations, sb.checked);
      if (sb.errors == 0) $display("tb_pgn_comment_filter OK");
      else $display("tb_pgn_comment_filter NOT OK");
      $finish;
   end
endmodule
